/* hw/rtl/ontdt_pkg.sv */
// Package with the constants, types and rounding helpers of the on-top density translation.
package ontdt_pkg;

  localparam int WORD_W     = 32;
  localparam int SQ_STEPS   = 28;
  localparam int RAD_W      = 56;
  localparam int ROOT_W     = RAD_W + 1;
  localparam int ROOT_OUT_W = 29;
  localparam int D_W        = 24;
  localparam int T_W        = 36;
  localparam int P_W        = 60;
  localparam int Z_W        = 30;
  localparam int M_W        = 62;

  localparam logic signed [32:0] Q_ONE = 33'sd16777216;
  localparam logic signed [32:0] Q_R0  = 33'sd15099494;
  localparam logic signed [32:0] Q_R1  = 33'sd19293798;
  localparam logic signed [Z_W-1:0] Z_ONE = 30'sd16777216;
  localparam logic signed [T_W-1:0] Q_A = -36'sd7979353990;
  localparam logic signed [T_W-1:0] Q_B = -36'sd6366505843;
  localparam logic signed [T_W-1:0] Q_C = -36'sd1432463815;

  localparam logic [1:0] ZSEL_NONE   = 2'd0;
  localparam logic [1:0] ZSEL_SQRT   = 2'd1;
  localparam logic [1:0] ZSEL_BRIDGE = 2'd2;

  typedef struct packed {
    logic                     zero;
    logic [1:0]               sel;
    logic signed [WORD_W-1:0] rho;
  } ontdt_ctl_t;

  // Rescale a Q.48 product to Q.24, rounding half toward plus infinity.
  function automatic logic signed [T_W-1:0] rnd24(input logic signed [P_W-1:0] p);
    logic signed [P_W-1:0] s;
    s = p + (P_W'(1) <<< 23);
    return s[P_W-1:24];
  endfunction

  // Halve and rescale the final product, then clamp to the signed word range.
  function automatic logic signed [WORD_W-1:0] round_sat(input logic signed [M_W-1:0] p);
    logic signed [M_W-1:0] s;
    logic signed [M_W-26:0] q;
    s = p + (M_W'(1) <<< 24);
    q = s[M_W-1:25];
    if (q > 37'sd2147483647) return 32'sh7fffffff;
    else if (q < -37'sd2147483648) return 32'sh80000000;
    else return q[WORD_W-1:0];
  endfunction

endpackage

/* hw/rtl/ontdt_if.sv */
// Handshake interfaces for the input, result and configuration channels.
interface ontdt_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rho;
  logic signed [31:0] pair_density;
  logic signed [31:0] ratio;
  modport source (output valid, rho, pair_density, ratio, input ready);
  modport sink (input valid, rho, pair_density, ratio, output ready);
  modport monitor (input valid, ready, rho, pair_density, ratio);
endinterface

interface ontdt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] alpha_density;
  logic signed [31:0] beta_density;
  modport source (output valid, alpha_density, beta_density, input ready);
  modport sink (input valid, alpha_density, beta_density, output ready);
  modport monitor (input valid, ready, alpha_density, beta_density);
endinterface

interface ontdt_cfg_if;
  logic valid;
  logic ready;
  logic translation_mode;
  modport source (output valid, translation_mode, input ready);
  modport sink (input valid, translation_mode, output ready);
  modport monitor (input valid, ready, translation_mode);
endinterface

/* hw/rtl/ontdt_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
module ontdt_isqrt (
  input  logic                              clk,
  input  logic                              en,
  input  logic [ontdt_pkg::RAD_W-1:0]       rad,
  output logic [ontdt_pkg::ROOT_OUT_W-1:0]  root
);
  import ontdt_pkg::*;

  logic [RAD_W-1:0]  n_r [SQ_STEPS-1];
  logic [ROOT_W-1:0] q_r [SQ_STEPS];

  genvar s;
  for (s = 0; s < SQ_STEPS; s++) begin : g_step
    localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (2 * (SQ_STEPS - 1 - s));
    logic [RAD_W-1:0]  n_in;
    logic [ROOT_W-1:0] q_in;
    logic [ROOT_W-1:0] trial;
    logic              take;

    if (s == 0) begin : g_first
      assign n_in = rad;
      assign q_in = '0;
    end else begin : g_next
      assign n_in = n_r[s-1];
      assign q_in = q_r[s-1];
    end

    assign trial = q_in + BIT;
    assign take  = {1'b0, n_in} >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[s] <= take ? ((q_in >> 1) + BIT) : (q_in >> 1);
      end
    end

    if (s < SQ_STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          n_r[s] <= take ? (n_in - trial[RAD_W-1:0]) : n_in;
        end
      end
    end
  end

  assign root = q_r[SQ_STEPS-1][ROOT_OUT_W-1:0];

endmodule

/* hw/rtl/on_top_density_translation.sv */
// Top level of the on-top density translation pipeline.
//
// Usage: each word on in_ch carries rho, pair_density and ratio of one grid
// point, all signed Q8.24. Each accepted word yields exactly one word on
// out_ch with the translated alpha and beta densities, in order.
// cfg_ch writes translation_mode (0 plain, 1 full with the quintic bridge);
// it is always ready and should only be written while the pipeline is empty.
// Throughput is one word per cycle while the skid register is empty. Each
// result passes through the input register, the 28 stages of the square
// root, one multiply stage and one round and saturate stage; the bridge
// polynomial runs alongside the square root.
// Reset (rst_n low, synchronous) empties the pipeline and sets
// translation_mode to 1. When the receiver stalls, the waiting result moves
// into a one-word skid register and the pipeline keeps accepting for that
// cycle; in_ch.ready drops only while the skid register is occupied.
module on_top_density_translation (
  input  logic                clk,
  input  logic                rst_n,
  ontdt_in_if.sink            in_ch,
  ontdt_out_if.source         out_ch,
  ontdt_cfg_if.sink           cfg_ch
);
  import ontdt_pkg::*;

  localparam int MUL_STG = SQ_STEPS + 1;
  localparam int OUT_STG = SQ_STEPS + 2;

  logic mode_r;
  logic en;
  logic in_fire;

  logic             v_r   [OUT_STG+1];
  ontdt_ctl_t       ctl_r [SQ_STEPS+1];
  logic [RAD_W-1:0] rad_r;
  logic [ROOT_OUT_W-1:0] root;

  logic signed [D_W-1:0] d0_r;
  logic signed [D_W-1:0] d_r [1:4];
  logic signed [P_W-1:0] p_r [1:5];
  logic signed [T_W-1:0] t_c [2:5];
  logic signed [T_W-1:0] zb_r [6:SQ_STEPS];

  logic signed [M_W-1:0]    ma_r, mb_r;
  logic signed [WORD_W-1:0] oa_r, ob_r;
  logic                     sk_full_r;
  logic signed [WORD_W-1:0] sk_a_r, sk_b_r;

  ontdt_ctl_t        ctl_in;
  logic signed [32:0] rx, one_minus, dx;
  logic signed [Z_W-1:0] zeta, fa, fb;

  assign cfg_ch.ready = 1'b1;
  assign en           = !sk_full_r;
  assign in_ch.ready  = en;
  assign in_fire      = in_ch.valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
    end else if (cfg_ch.valid) begin
      mode_r <= cfg_ch.translation_mode;
    end
  end

  // Decode the branch before the first stage register.
  always_comb begin
    rx        = 33'(in_ch.ratio);
    one_minus = Q_ONE - rx;
    dx        = rx - Q_R1;
    ctl_in.rho  = in_ch.rho;
    ctl_in.zero = (in_ch.rho <= 32'sd0) || (in_ch.pair_density < 32'sd0);
    ctl_in.sel  = ZSEL_NONE;
    if (!mode_r) begin
      if (rx < Q_ONE) ctl_in.sel = ZSEL_SQRT;
    end else begin
      priority if (rx < Q_R0) ctl_in.sel = ZSEL_SQRT;
      else if (rx <= Q_R1) ctl_in.sel = ZSEL_BRIDGE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= OUT_STG; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_fire;
      for (int i = 1; i <= OUT_STG; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0] <= ctl_in;
      rad_r    <= {one_minus[31:0], 24'd0};
      d0_r     <= dx[D_W-1:0];
      for (int i = 1; i <= SQ_STEPS; i++) ctl_r[i] <= ctl_r[i-1];
    end
  end

  ontdt_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad_r),
    .root (root)
  );

  // Horner evaluation of the bridge, one multiply per stage.
  always_comb begin
    t_c[2] = Q_B + rnd24(p_r[1]);
    t_c[3] = Q_C + rnd24(p_r[2]);
    t_c[4] = rnd24(p_r[3]);
    t_c[5] = rnd24(p_r[4]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[1] <= Q_A * d0_r;
      d_r[1] <= d0_r;
      for (int k = 2; k <= 5; k++) p_r[k] <= t_c[k] * d_r[k-1];
      for (int k = 2; k <= 4; k++) d_r[k] <= d_r[k-1];
      zb_r[6] <= rnd24(p_r[5]);
      for (int k = 7; k <= SQ_STEPS; k++) zb_r[k] <= zb_r[k-1];
    end
  end

  always_comb begin
    unique case (ctl_r[SQ_STEPS].sel)
      ZSEL_SQRT:   zeta = {1'b0, root};
      ZSEL_BRIDGE: zeta = zb_r[SQ_STEPS][Z_W-1:0];
      default:     zeta = '0;
    endcase
    if (ctl_r[SQ_STEPS].zero) begin
      fa = '0;
      fb = '0;
    end else begin
      fa = Z_ONE + zeta;
      fb = Z_ONE - zeta;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r <= fa * ctl_r[SQ_STEPS].rho;
      mb_r <= fb * ctl_r[SQ_STEPS].rho;
      oa_r <= round_sat(ma_r);
      ob_r <= round_sat(mb_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sk_full_r <= 1'b0;
    end else if (sk_full_r) begin
      if (out_ch.ready) sk_full_r <= 1'b0;
    end else if (v_r[OUT_STG] && !out_ch.ready) begin
      sk_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!sk_full_r) begin
      sk_a_r <= oa_r;
      sk_b_r <= ob_r;
    end
  end

  assign out_ch.valid         = sk_full_r || v_r[OUT_STG];
  assign out_ch.alpha_density = sk_full_r ? sk_a_r : oa_r;
  assign out_ch.beta_density  = sk_full_r ? sk_b_r : ob_r;

`ifndef SYNTH
  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (sk_full_r && !out_ch.ready) |=> (sk_full_r && $stable(sk_a_r) && $stable(sk_b_r)))
    else $error("skid word changed while the receiver stalled");
  a_mode_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_ch.valid |=> $stable(mode_r))
    else $error("translation mode changed without a write");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(v_r[OUT_STG]) && $stable(oa_r) && $stable(ob_r)))
    else $error("last stage moved during a stall");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!sk_full_r && !v_r[0] && !v_r[OUT_STG]))
    else $error("pipeline not empty after reset");
`endif

endmodule

/* bench/ontdt_checker.sv */
// Checker that predicts and compares the translated densities on the result channel.
`timescale 1ns / 100ps
module ontdt_checker (
  input  logic          clk,
  input  logic          rst_n,
  ontdt_in_if.monitor   in_mon,
  ontdt_out_if.monitor  out_mon,
  ontdt_cfg_if.monitor  cfg_mon,
  output int            fail_count,
  output int            pending_count
);
  import ontdt_pkg::*;

  localparam longint ONE_Q = 64'sd16777216;
  localparam longint R0_Q  = 64'sd15099494;
  localparam longint R1_Q  = 64'sd19293798;
  localparam longint A_Q   = -64'sd7979353990;
  localparam longint B_Q   = -64'sd6366505843;
  localparam longint C_Q   = -64'sd1432463815;

  logic mode_q;
  logic [31:0] alpha_exp_q[$];
  logic [31:0] beta_exp_q[$];

  // Round to nearest with ties toward plus infinity; >>> floors on signed values.
  function automatic longint round_shift(input longint p, input int s);
    longint q;
    q = p + (64'sd1 <<< (s - 1));
    return q >>> s;
  endfunction

  function automatic longint int_root(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic logic [31:0] clamp_word(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic longint polarization(input logic full, input longint r);
    longint d, t;
    if (!full) begin
      if (r < ONE_Q) return int_root(longint'(ONE_Q - r) << 24);
      return 0;
    end
    if (r < R0_Q) return int_root(longint'(ONE_Q - r) << 24);
    if (r > R1_Q) return 0;
    d = r - R1_Q;
    t = B_Q + round_shift(A_Q * d, 24);
    t = C_Q + round_shift(t * d, 24);
    t = round_shift(t * d, 24);
    t = round_shift(t * d, 24);
    return round_shift(t * d, 24);
  endfunction

  assign pending_count = alpha_exp_q.size();

  always_ff @(posedge clk) begin
    longint rho, pd, z;
    logic [31:0] ea, eb;
    if (!rst_n) begin
      mode_q <= 1'b1;
      fail_count <= 0;
      alpha_exp_q.delete();
      beta_exp_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) mode_q <= cfg_mon.translation_mode;
      if (in_mon.valid && in_mon.ready) begin
        rho = longint'(in_mon.rho);
        pd = longint'(in_mon.pair_density);
        if (rho <= 0 || pd < 0) begin
          alpha_exp_q.push_back(32'd0);
          beta_exp_q.push_back(32'd0);
        end else begin
          z = polarization(mode_q, longint'(in_mon.ratio));
          alpha_exp_q.push_back(clamp_word(round_shift((ONE_Q + z) * rho, 25)));
          beta_exp_q.push_back(clamp_word(round_shift((ONE_Q - z) * rho, 25)));
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (alpha_exp_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result word %h %h",
                                        out_mon.alpha_density, out_mon.beta_density);
        end else begin
          ea = alpha_exp_q.pop_front();
          eb = beta_exp_q.pop_front();
          if (ea !== out_mon.alpha_density || eb !== out_mon.beta_density) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: alpha exp %h got %h, beta exp %h got %h",
                       ea, out_mon.alpha_density, eb, out_mon.beta_density);
          end
        end
      end
    end
  end
endmodule

/* bench/tb_top.sv */
// Testbench top: drives points and mode writes into the translation block and gives the verdict.
`timescale 1ns / 100ps
module tb_top;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending_count;
  int   send_idle = 30, recv_idle = 80;
  bit   hold_recv = 1'b0;
  longint cycles = 0;

  ontdt_in_if  in_ch ();
  ontdt_out_if out_ch ();
  ontdt_cfg_if cfg_ch ();

  on_top_density_translation u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  ontdt_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.rho = '0;
    in_ch.pair_density = '0;
    in_ch.ratio = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.translation_mode = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL on_top_density_translation");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || hold_recv) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_point(input logic [31:0] r, input logic [31:0] p, input logic [31:0] q);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rho <= r;
    in_ch.pair_density <= p;
    in_ch.ratio <= q;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_ch.valid <= 1'b1;
    cfg_ch.translation_mode <= m;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Ratio values clustered around the sqrt, bridge and zero regions.
  function automatic logic [31:0] pick_ratio();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(15099494 + 300, 15099494 - 300);
      2: return $urandom_range(19293798 + 300, 19293798 - 300);
      3: return $urandom_range(16777216 + 300, 16777216 - 300);
      4: return $urandom_range(19400000, 15000000);
      default: return $urandom_range(16777216, 0);
    endcase
  endfunction

  task automatic random_points(input int n);
    logic [31:0] r, p;
    for (int i = 0; i < n; i++) begin
      r = ($urandom_range(9) == 0) ? $urandom : $urandom_range(32'h7fffffff, 1);
      if ($urandom_range(3) == 0) r = $urandom_range(32'h00ffffff, 1);
      p = ($urandom_range(9) == 0) ? $urandom : $urandom_range(32'h7fffffff, 0);
      send_point(r, p, pick_ratio());
    end
  endtask

  initial begin
    logic [31:0] edge_vals[6];
    edge_vals = '{32'h80000000, 32'hffffffff, 32'h0, 32'h1, 32'h01000000, 32'h7fffffff};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: sign guards, saturation, each zeta region in both modes.
    foreach (edge_vals[i]) send_point(edge_vals[i], 32'h01000000, 32'h00800000);
    send_point(32'h7fffffff, 32'h0, 32'h80000000);
    send_point(32'h01000000, 32'hffffffff, 32'h0);
    send_point(32'h01000000, 32'h7fffffff, 32'h7fffffff);
    send_point(32'h01000000, 32'h0, 32'd15099493);
    send_point(32'h01000000, 32'h0, 32'd15099494);
    send_point(32'h01000000, 32'h0, 32'd19293798);
    send_point(32'h01000000, 32'h0, 32'd19293799);
    send_point(32'h01000000, 32'h0, 32'd16777216);
    drain();
    write_mode(1'b0);
    send_point(32'h7fffffff, 32'h0, 32'h80000000);
    send_point(32'h01000000, 32'h0, 32'd16777215);
    send_point(32'h01000000, 32'h0, 32'd16777216);
    send_point(32'h01000000, 32'h0, 32'd15099494);
    random_points(200);
    drain();
    write_mode(1'b1);
    send_idle = 80;
    recv_idle = 30;
    random_points(200);
    // Long receiver hold-off while the sender keeps offering.
    hold_recv = 1'b1;
    fork
      random_points(60);
      begin
        repeat (150) @(posedge clk);
        hold_recv = 1'b0;
      end
    join
    drain();
    write_mode(1'b0);
    send_idle = 0;
    recv_idle = 0;
    random_points(180);
    drain();
    write_mode(1'b1);
    random_points(190);
    drain();
    if (fail_count == 0) begin
      $display("PASS on_top_density_translation");
    end else begin
      $display("FAIL on_top_density_translation");
    end
    $finish;
  end
endmodule

/* files.f */
hw/rtl/ontdt_pkg.sv
hw/rtl/ontdt_if.sv
hw/rtl/ontdt_isqrt.sv
hw/rtl/on_top_density_translation.sv
bench/ontdt_checker.sv
bench/tb_top.sv
